### rtl/rdsm_pkg.sv
// shared types and constants for the dot-star pattern matcher
`timescale 1ns / 1ps
`default_nettype none

package rdsm_pkg;

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_TEXT    = 2'd1,
      CMD_EVAL    = 2'd2
   } cmd_type;

   localparam logic [7:0] SYM_ANY  = 8'h2E;
   localparam logic [7:0] SYM_STAR = 8'h2A;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 8;

   typedef struct packed {
      logic malformed;
      logic matched;
   } verdict_type;

endpackage : rdsm_pkg

`default_nettype wire

### rtl/rdsm_closure.sv
// star-skip closure of the position set as a parallel prefix network
`timescale 1ns / 1ps
`default_nettype none

module rdsm_closure #(
   parameter int unsigned WIDTH = 33
) (
   input  wire logic [WIDTH-1:0] set_in,
   input  wire logic [WIDTH-2:0] skip_in,
   output logic      [WIDTH-1:0] set_out
);

   localparam int unsigned LEVELS = (WIDTH > 2) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] gen_lvl [LEVELS+1];
   logic [WIDTH-1:0] prop_lvl [LEVELS+1];

   // position i inherits from i-1 when atom i-1 is starred
   always_comb begin
      int unsigned span;
      gen_lvl[0]  = set_in;
      prop_lvl[0] = {skip_in, 1'b0};
      for (int unsigned lvl = 0; lvl < LEVELS; lvl++) begin
         span = 1 << lvl;
         for (int unsigned i = 0; i < WIDTH; i++) begin
            if (i >= span) begin
               gen_lvl[lvl+1][i]  = gen_lvl[lvl][i]
                                  | (prop_lvl[lvl][i] & gen_lvl[lvl][i-span]);
               prop_lvl[lvl+1][i] = prop_lvl[lvl][i] & prop_lvl[lvl][i-span];
            end else begin
               gen_lvl[lvl+1][i]  = gen_lvl[lvl][i];
               prop_lvl[lvl+1][i] = 1'b0;
            end
         end
      end
      set_out = gen_lvl[LEVELS];
   end

endmodule : rdsm_closure

`default_nettype wire

### rtl/regex_dot_star_matcher.sv
// top level of the dot-star pattern matcher
`timescale 1ns / 1ps
`default_nettype none

// Whole-text matcher for patterns of literal bytes, '.' (any byte) and '*'
// (zero or more of the previous atom). Each request carries a command in
// tuser: append a pattern byte, consume a text byte, or evaluate. Only
// evaluate returns a response (matched, malformed) and then clears the
// pattern for the next job. One request is taken every cycle while the
// request side does not stall; a request goes from the input register to
// the state, and an evaluate's verdict is registered into the response
// register when the evaluate leaves the input register.
// The set of reachable pattern positions is updated combinationally; the
// star-skip prefix network over MAX_TOKENS+1 positions sets the critical
// path. The request side stalls only while an evaluate waits behind an
// untaken response.
module regex_dot_star_matcher
   import rdsm_pkg::*;
#(
   parameter int unsigned MAX_TOKENS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] symbol
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] matched, [1] malformed, [7:2] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned POS_W = MAX_TOKENS + 1;
   localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);

   // input register
   logic       stg_valid_ff, stg_valid_in;
   cmd_type    stg_cmd_ff;
   logic [7:0] stg_sym_ff;

   // pattern and walk state
   logic [7:0]            chars_ff [MAX_TOKENS];
   logic [MAX_TOKENS-1:0] starred_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [POS_W-1:0]      active_ff, active_in;
   logic                  error_ff, error_in;
   logic                  last_star_ff, last_star_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_data_ff;

   logic                  advance;
   logic                  do_pattern, do_text, do_eval;
   logic                  append_char, append_star;
   logic                  sym_is_star, count_full, count_zero;
   logic [POS_W-1:0]      closed_set;
   logic [MAX_TOKENS-1:0] lane_valid, lane_hit;
   logic [POS_W-1:0]      next_set;
   logic                  end_reached;
   verdict_type           verdict;

   rdsm_closure #(
      .WIDTH (POS_W)
   ) u_closure (
      .set_in  (active_ff),
      .skip_in (starred_ff),
      .set_out (closed_set)
   );

   assign advance = stg_valid_ff &&
                    ((stg_cmd_ff != CMD_EVAL) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !stg_valid_ff || advance;

   always_comb begin
      do_pattern = 1'b0;
      do_text    = 1'b0;
      do_eval    = 1'b0;
      unique case (stg_cmd_ff)
         CMD_PATTERN: do_pattern = advance;
         CMD_TEXT:    do_text    = advance;
         CMD_EVAL:    do_eval    = advance;
         default: ;
      endcase
   end

   assign sym_is_star = (stg_sym_ff == SYM_STAR);
   assign count_full  = (count_ff == CNT_W'(MAX_TOKENS));
   assign count_zero  = (count_ff == '0);
   assign append_star = do_pattern && !error_ff && sym_is_star &&
                        !last_star_ff && !count_zero;
   assign append_char = do_pattern && !error_ff && !sym_is_star && !count_full;

   // per-lane byte compare against the text byte
   always_comb begin
      for (int unsigned i = 0; i < MAX_TOKENS; i++) begin
         lane_valid[i] = (CNT_W'(i) < count_ff);
         lane_hit[i]   = closed_set[i] && lane_valid[i] &&
                         ((chars_ff[i] == SYM_ANY) || (chars_ff[i] == stg_sym_ff));
      end
   end

   assign next_set = {1'b0, lane_hit & starred_ff} | {lane_hit & ~starred_ff, 1'b0};

   assign end_reached       = closed_set[count_ff];
   assign verdict.malformed = error_ff;
   assign verdict.matched   = !error_ff && end_reached;

   always_comb begin
      count_in     = count_ff;
      active_in    = active_ff;
      error_in     = error_ff;
      last_star_in = last_star_ff;
      if (do_eval) begin
         count_in     = '0;
         active_in    = POS_W'(1);
         error_in     = 1'b0;
         last_star_in = 1'b1;
      end else if (do_text) begin
         active_in = next_set;
      end else if (do_pattern && !error_ff) begin
         if (append_star) begin
            last_star_in = 1'b1;
         end else if (append_char) begin
            count_in     = count_ff + CNT_W'(1);
            last_star_in = 1'b0;
         end else begin
            error_in = 1'b1;
         end
      end
   end

   assign stg_valid_in = (req_tvalid && req_tready) || (stg_valid_ff && !advance);
   assign rsp_valid_in = do_eval || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         active_ff    <= POS_W'(1);
         error_ff     <= 1'b0;
         last_star_ff <= 1'b1;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         error_ff     <= error_in;
         last_star_ff <= last_star_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stg_cmd_ff <= cmd_type'(req_tuser);
         stg_sym_ff <= req_tdata;
      end
      if (do_eval) begin
         rsp_data_ff <= verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || do_eval) begin
         starred_ff <= '0;
      end else begin
         for (int unsigned i = 0; i < MAX_TOKENS; i++) begin
            if (append_char && (CNT_W'(i) == count_ff)) begin
               starred_ff[i] <= 1'b0;
            end else if (append_star && (CNT_W'(i + 1) == count_ff)) begin
               starred_ff[i] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned i = 0; i < MAX_TOKENS; i++) begin
         if (append_char && (CNT_W'(i) == count_ff)) begin
            chars_ff[i] <= stg_sym_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2)'(0), rsp_data_ff.malformed, rsp_data_ff.matched};

endmodule : regex_dot_star_matcher

`default_nettype wire
